// File: sv/small_set_algebra_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the small set algebra engine
// Both macros sample on clk and are switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SMALL_SET_ALGEBRA_ENGINE_ASSERT_SVH
`define SMALL_SET_ALGEBRA_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSAE_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSAE_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ssae_pkg.sv
// ----------------------------------------------------------------------------
// ssae_pkg
// Shared constants, codes and types of the small set algebra engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssae_pkg;

	localparam int CAPACITY = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ELEM_W   = 8;

	localparam logic [2:0] ACT_INSERT = 3'd0;
	localparam logic [2:0] ACT_LIST   = 3'd1;
	localparam logic [2:0] ACT_UNION  = 3'd2;
	localparam logic [2:0] ACT_INTER  = 3'd3;
	localparam logic [2:0] ACT_AMB    = 3'd4;
	localparam logic [2:0] ACT_BMA    = 3'd5;

	localparam logic [1:0] STAT_ADDED = 2'd0;
	localparam logic [1:0] STAT_DUP   = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_QUERY = 2'd3;

	typedef enum logic [1:0] {
		MODE_ALL,
		MODE_IN,
		MODE_NOTIN
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_CHK,
		ST_INS_ACT,
		ST_Q_CMP,
		ST_Q_DEC,
		ST_Q_END
	} state_t;

	// Control of one row of cells for one set.
	typedef struct packed {
		logic              rotate;
		logic              load;
		logic [ELEM_W-1:0] load_val;
		logic [ELEM_W-1:0] key;
	} row_ctrl_t;

endpackage

// File: sv/small_set_algebra_engine.sv
// ----------------------------------------------------------------------------
// small_set_algebra_engine
// Two byte sets kept in rings of cells, with insert and streaming queries
// for list, union, intersection and both differences.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// in      | sink      | in_valid/in_ready   | action, set_select, element
// out     | source    | out_valid/out_ready | member, has_member, status, last
//
// An insert passes through accept, compare and decide; its status beat is
// registered in the decide step, which waits for a free output.
// A query visits each source element with a compare step, then a decide step
// on the registered match of the other ring; each pass end and the closing
// beat take a step of their own, and a union makes a pass over each set.
// Reset clears the counts and the control; the cells hold no reset value.
// A beat that meets a stalled output halts the engine; one input at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module small_set_algebra_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  action,
	input  logic                        set_select,
	input  logic [ssae_pkg::ELEM_W-1:0] element,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ssae_pkg::ELEM_W-1:0] member,
	output logic                        has_member,
	output logic [1:0]                  status,
	output logic                        last
);
	import ssae_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_a_q, count_b_q;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic              src_q, src_d;
	mode_t             mode_q, mode_d;
	logic              union_q, union_d;
	logic              pend_valid_q, pend_valid_d;
	logic [ELEM_W-1:0] pend_val_q, pend_val_d;
	logic [ELEM_W-1:0] elem_q;
	logic              sel_q;

	logic              out_valid_q;
	logic [ELEM_W-1:0] member_q;
	logic              has_q;
	logic [1:0]        status_q;
	logic              last_q;

	logic              out_free;
	logic              out_load;
	logic [ELEM_W-1:0] out_member_d;
	logic              out_has_d;
	logic [1:0]        out_status_d;
	logic              out_last_d;
	logic              ins_load;
	logic              rot;

	logic [ELEM_W-1:0] head_a, head_b;
	logic              hit_a, hit_b;
	row_ctrl_t         ctrl_a, ctrl_b;
	logic [CNT_W-1:0]  src_count;
	logic              hit_other;
	logic              hit_sel;
	logic [CNT_W-1:0]  count_sel;
	logic              take;
	logic              ins_key;

	assign out_free  = !out_valid_q || out_ready;
	assign src_count = src_q ? count_b_q : count_a_q;
	assign hit_other = src_q ? hit_a : hit_b;
	assign hit_sel   = sel_q ? hit_b : hit_a;
	assign count_sel = sel_q ? count_b_q : count_a_q;
	assign take      = (mode_q == MODE_ALL) || ((mode_q == MODE_IN) && hit_other)
	                   || ((mode_q == MODE_NOTIN) && !hit_other);

	// The key stays on the new byte while its status beat waits, so that the
	// registered match is still valid when the output frees up.
	assign ins_key   = (state_q == ST_INS_CHK) || (state_q == ST_INS_ACT);

	always_comb begin
		ctrl_a.rotate   = rot && !src_q;
		ctrl_a.load     = ins_load && !sel_q;
		ctrl_a.load_val = elem_q;
		ctrl_a.key      = ins_key ? elem_q : head_b;
		ctrl_b.rotate   = rot && src_q;
		ctrl_b.load     = ins_load && sel_q;
		ctrl_b.load_val = elem_q;
		ctrl_b.key      = ins_key ? elem_q : head_a;
	end

	ssae_row u_row_a (
		.clk   (clk),
		.count (count_a_q),
		.ctrl  (ctrl_a),
		.head  (head_a),
		.hit   (hit_a)
	);

	ssae_row u_row_b (
		.clk   (clk),
		.count (count_b_q),
		.ctrl  (ctrl_b),
		.head  (head_b),
		.hit   (hit_b)
	);

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		src_d        = src_q;
		mode_d       = mode_q;
		union_d      = union_q;
		pend_valid_d = pend_valid_q;
		pend_val_d   = pend_val_q;
		in_ready     = 1'b0;
		out_load     = 1'b0;
		out_member_d = '0;
		out_has_d    = 1'b0;
		out_status_d = STAT_QUERY;
		out_last_d   = 1'b1;
		ins_load     = 1'b0;
		rot          = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				idx_d        = '0;
				union_d      = 1'b0;
				pend_valid_d = 1'b0;
				if (in_valid) begin
					state_d = ST_Q_CMP;
					unique case (action)
						ACT_INSERT: begin
							state_d = ST_INS_CHK;
						end
						ACT_LIST: begin
							src_d  = set_select;
							mode_d = MODE_ALL;
						end
						ACT_UNION: begin
							src_d   = 1'b0;
							mode_d  = MODE_ALL;
							union_d = 1'b1;
						end
						ACT_INTER: begin
							src_d  = 1'b1;
							mode_d = MODE_IN;
						end
						ACT_AMB: begin
							src_d  = 1'b0;
							mode_d = MODE_NOTIN;
						end
						ACT_BMA: begin
							src_d  = 1'b1;
							mode_d = MODE_NOTIN;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_INS_CHK: begin
				state_d = ST_INS_ACT;
			end
			ST_INS_ACT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (hit_sel) begin
						out_status_d = STAT_DUP;
					end else if (count_sel == CNT_W'(CAPACITY)) begin
						out_status_d = STAT_FULL;
					end else begin
						out_status_d = STAT_ADDED;
						ins_load     = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			ST_Q_CMP: begin
				if (idx_q == src_count) begin
					if (union_q) begin
						src_d   = 1'b1;
						mode_d  = MODE_NOTIN;
						union_d = 1'b0;
						idx_d   = '0;
					end else begin
						state_d = ST_Q_END;
					end
				end else begin
					state_d = ST_Q_DEC;
				end
			end
			ST_Q_DEC: begin
				// A taken element is held back until the next one is taken, so that the
				// final beat of the answer can be marked last.
				if (!(take && pend_valid_q && !out_free)) begin
					if (take) begin
						if (pend_valid_q) begin
							out_load     = 1'b1;
							out_member_d = pend_val_q;
							out_has_d    = 1'b1;
							out_last_d   = 1'b0;
						end
						pend_valid_d = 1'b1;
						pend_val_d   = src_q ? head_b : head_a;
					end
					rot     = 1'b1;
					idx_d   = idx_q + CNT_W'(1);
					state_d = ST_Q_CMP;
				end
			end
			ST_Q_END: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_member_d = pend_valid_q ? pend_val_q : '0;
					out_has_d    = pend_valid_q;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_a_q    <= '0;
			count_b_q    <= '0;
			idx_q        <= '0;
			src_q        <= 1'b0;
			mode_q       <= MODE_ALL;
			union_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			idx_q        <= idx_d;
			src_q        <= src_d;
			mode_q       <= mode_d;
			union_q      <= union_d;
			pend_valid_q <= pend_valid_d;
			if (ins_load && !sel_q) begin
				count_a_q <= count_a_q + CNT_W'(1);
			end
			if (ins_load && sel_q) begin
				count_b_q <= count_b_q + CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_val_q <= pend_val_d;
		if (in_valid && in_ready) begin
			elem_q <= element;
			sel_q  <= set_select;
		end
		if (out_load) begin
			member_q <= out_member_d;
			has_q    <= out_has_d;
			status_q <= out_status_d;
			last_q   <= out_last_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign member     = member_q;
	assign has_member = has_q;
	assign status     = status_q;
	assign last       = last_q;

`include "small_set_algebra_engine_assert.svh"

	`SSAE_ASSERT_IMP(a_count_a_cap, 1'b1, count_a_q <= CNT_W'(CAPACITY), "count of set A beyond capacity")
	`SSAE_ASSERT_IMP(a_count_b_cap, 1'b1, count_b_q <= CNT_W'(CAPACITY), "count of set B beyond capacity")
	`SSAE_ASSERT_IMP(a_idx_range, state_q == ST_Q_DEC, idx_q < src_count, "query step past the end of the set")
	`SSAE_ASSERT_IMP(a_end_no_union, state_q == ST_Q_END, !union_q, "query ended before the second union pass")
	`SSAE_ASSERT_NXT(a_ins_grow, ins_load, count_sel == $past(count_sel) + CNT_W'(1), "append did not grow the set")

endmodule

// File: sv/ssae_cell.sv
// ----------------------------------------------------------------------------
// ssae_cell
// One storage cell: holds one element, takes its neighbour's value on a
// rotate, loads a new element on an append, and compares with a key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssae_cell (
	input  logic                       clk,
	input  logic                       shift,
	input  logic [ssae_pkg::ELEM_W-1:0] shift_in,
	input  logic                       load,
	input  logic [ssae_pkg::ELEM_W-1:0] load_val,
	input  logic [ssae_pkg::ELEM_W-1:0] key,
	output logic [ssae_pkg::ELEM_W-1:0] value,
	output logic                       match
);
	import ssae_pkg::*;

	logic [ELEM_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= load_val;
		end else if (shift) begin
			value_q <= shift_in;
		end
	end

	assign value = value_q;
	assign match = (value_q == key);

endmodule

// File: sv/ssae_row.sv
// ----------------------------------------------------------------------------
// ssae_row
// A ring of cells holding one set in insertion order. Cell 0 is the head.
// A rotate moves every occupied cell one place towards the head, the head
// wrapping round to the last occupied cell, so a full turn restores order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssae_row (
	input  logic                        clk,
	input  logic [ssae_pkg::CNT_W-1:0]  count,
	input  ssae_pkg::row_ctrl_t         ctrl,
	output logic [ssae_pkg::ELEM_W-1:0] head,
	output logic                        hit
);
	import ssae_pkg::*;

	logic [ELEM_W-1:0]   value [CAPACITY];
	logic [CAPACITY-1:0] match;
	logic [CAPACITY-1:0] occupied;
	logic [CAPACITY-1:0] hit_vec_s1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int NXT = (i + 1) % CAPACITY;
		logic [ELEM_W-1:0] shift_in;

		assign occupied[i] = (CNT_W'(i) < count);
		assign shift_in    = (CNT_W'(i + 1) == count) ? value[0] : value[NXT];

		ssae_cell u_cell (
			.clk      (clk),
			.shift    (ctrl.rotate && occupied[i]),
			.shift_in (shift_in),
			.load     (ctrl.load && (CNT_W'(i) == count)),
			.load_val (ctrl.load_val),
			.key      (ctrl.key),
			.value    (value[i]),
			.match    (match[i])
		);
	end

	// Match bits are registered before the reduction, so hit reflects the key
	// of the previous cycle.
	always_ff @(posedge clk) begin
		hit_vec_s1 <= match & occupied;
	end

	assign hit  = |hit_vec_s1;
	assign head = value[0];

endmodule
